/* rtl/cmfs_pkg.sv */
// Package for the format-4 character map segment builder.
// Holds field widths, limits, the queue command type and the hint helper.
// No dependencies.
package cmfs_pkg;

  localparam int CodeW  = 21;
  localparam int GlyphW = 16;
  localparam int SegW   = 16;
  localparam int SelW   = 4;
  localparam int CountW = 17;

  localparam int QDepth = 4;

  localparam logic [SegW-1:0]   TermCode  = 16'hFFFF;
  localparam logic [SegW-1:0]   TermDelta = 16'd1;
  localparam logic [CountW-1:0] SegLimit  = 17'd65535;

  localparam logic KindPair   = 1'b0;
  localparam logic KindFinish = 1'b1;

  typedef struct packed {
    logic            has_seg;
    logic [SegW-1:0] seg_start;
    logic [SegW-1:0] seg_end;
    logic [SegW-1:0] seg_delta;
    logic            is_fin;
    logic            err;
    logic [SegW-1:0] total;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [SelW-1:0] floor_log2(input logic [SegW-1:0] v);
    logic [SelW-1:0] r;
    r = '0;
    for (int i = 1; i < SegW; i++) begin
      if (v[i]) begin
        r = SelW'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/cmfs_if.sv */
// Channel interfaces for pair input and segment output.
// Depends on cmfs_pkg for field widths.
interface cmfs_pair_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [cmfs_pkg::CodeW-1:0] code;
  logic [cmfs_pkg::GlyphW-1:0] glyph;

  modport source (output valid, kind, code, glyph, input ready);
  modport sink (input valid, kind, code, glyph, output ready);
endinterface

interface cmfs_seg_if;
  logic                       valid;
  logic                       ready;
  logic [cmfs_pkg::SegW-1:0]  seg_start;
  logic [cmfs_pkg::SegW-1:0]  seg_end;
  logic [cmfs_pkg::SegW-1:0]  seg_delta;
  logic [cmfs_pkg::SegW-1:0]  seg_total;
  logic [cmfs_pkg::SegW-1:0]  range_hint;
  logic [cmfs_pkg::SelW-1:0]  selector_hint;
  logic [cmfs_pkg::SegW-1:0]  shift_hint;
  logic                       error;
  logic                       last;

  modport source (output valid, seg_start, seg_end, seg_delta, seg_total, range_hint,
                  selector_hint, shift_hint, error, last, input ready);
  modport sink (input valid, seg_start, seg_end, seg_delta, seg_total, range_hint,
                selector_hint, shift_hint, error, last, output ready);
endinterface

/* rtl/cmfs_front.sv */
// Front end: accepts pairs and finish items, tracks the open segment and
// pushes one command per item that causes output. Depends on cmfs_pkg.
module cmfs_front (
  input  logic                 clk,
  input  logic                 rst,
  cmfs_pair_if.sink            pairs,
  input  cmfs_pkg::fifo_stat_t q_stat,
  output logic                 q_push,
  output cmfs_pkg::cmd_t       q_cmd
);
  import cmfs_pkg::*;

  logic [SegW-1:0]   run_first;
  logic [SegW-1:0]   run_final;
  logic [SegW-1:0]   run_offset;
  logic              run_open;
  logic [CountW-1:0] segments_emitted;
  logic              error_seen;

  logic              take;
  logic              code_ok;
  logic [SegW-1:0]   code16;
  logic [SegW-1:0]   delta;
  logic              extend;
  logic [CountW-1:0] emitted_inc;
  logic [CountW-1:0] total;

  assign pairs.ready = !q_stat.full;
  assign take        = pairs.valid && pairs.ready;
  assign code_ok     = (pairs.code[CodeW-1:SegW] == '0);
  assign code16      = pairs.code[SegW-1:0];
  assign delta       = pairs.glyph - code16;
  assign extend      = run_open && ({1'b0, code16} == {1'b0, run_final} + 17'd1)
                       && (delta == run_offset);
  assign emitted_inc = segments_emitted + 17'd1;
  assign total       = segments_emitted + {16'd0, run_open} + 17'd1;

  always_comb begin
    q_push = 1'b0;
    q_cmd  = '0;
    if (take) begin
      if (pairs.kind == KindPair) begin
        if (!error_seen && code_ok && !extend && run_open) begin
          q_push          = 1'b1;
          q_cmd.has_seg   = 1'b1;
          q_cmd.seg_start = run_first;
          q_cmd.seg_end   = run_final;
          q_cmd.seg_delta = run_offset;
        end
      end else begin
        q_push       = 1'b1;
        q_cmd.is_fin = 1'b1;
        if (error_seen || total > SegLimit) begin
          q_cmd.err = 1'b1;
        end else begin
          q_cmd.has_seg   = run_open;
          q_cmd.seg_start = run_first;
          q_cmd.seg_end   = run_final;
          q_cmd.seg_delta = run_offset;
          q_cmd.total     = total[SegW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_first        <= '0;
      run_final        <= '0;
      run_offset       <= '0;
      run_open         <= 1'b0;
      segments_emitted <= '0;
      error_seen       <= 1'b0;
    end else if (take) begin
      if (pairs.kind == KindFinish) begin
        run_first        <= '0;
        run_final        <= '0;
        run_offset       <= '0;
        run_open         <= 1'b0;
        segments_emitted <= '0;
        error_seen       <= 1'b0;
      end else if (!error_seen) begin
        if (!code_ok) begin
          error_seen <= 1'b1;
        end else if (extend) begin
          run_final <= code16;
        end else begin
          if (run_open) begin
            segments_emitted <= emitted_inc;
            if (emitted_inc + 17'd2 > SegLimit) begin
              error_seen <= 1'b1;
            end
          end
          run_first  <= code16;
          run_final  <= code16;
          run_offset <= delta;
          run_open   <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/cmfs_fifo.sv */
// Short command queue between the front and back ends.
// Register-based, one write and one read per cycle. Depends on cmfs_pkg.
module cmfs_fifo #(
  parameter int DEPTH = cmfs_pkg::QDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cmfs_pkg::cmd_t       wdata,
  input  logic                 pop,
  output cmfs_pkg::cmd_t       head,
  output cmfs_pkg::fifo_stat_t stat
);
  import cmfs_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == FullCnt);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

/* rtl/cmfs_back.sv */
// Back end: turns queued commands into segment results, computes the
// search hints for the terminator and holds the output register. Depends on cmfs_pkg.
module cmfs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  cmfs_pkg::cmd_t       head,
  input  cmfs_pkg::fifo_stat_t q_stat,
  output logic                 q_pop,
  cmfs_seg_if.source           segs
);
  import cmfs_pkg::*;

  logic              phase;
  logic              load;
  logic              produce;
  logic              send_seg;
  logic              entry_done;
  logic [SelW-1:0]   sel;
  logic [SegW:0]     range_wide;
  logic [SegW-1:0]   range_val;

  assign load       = !segs.valid || segs.ready;
  assign produce    = !q_stat.empty && load;
  assign send_seg   = head.has_seg && !phase;
  assign entry_done = !send_seg || !head.is_fin;
  assign q_pop      = produce && entry_done;

  assign sel        = floor_log2(head.total);
  assign range_wide = (SegW+1)'(2) << sel;
  assign range_val  = range_wide[SegW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      segs.valid <= 1'b0;
      phase      <= 1'b0;
    end else begin
      if (produce) begin
        segs.valid <= 1'b1;
        phase      <= !entry_done;
      end else if (segs.ready) begin
        segs.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      if (send_seg) begin
        segs.seg_start     <= head.seg_start;
        segs.seg_end       <= head.seg_end;
        segs.seg_delta     <= head.seg_delta;
        segs.seg_total     <= '0;
        segs.range_hint    <= '0;
        segs.selector_hint <= '0;
        segs.shift_hint    <= '0;
        segs.error         <= 1'b0;
        segs.last          <= 1'b0;
      end else if (head.err) begin
        segs.seg_start     <= '0;
        segs.seg_end       <= '0;
        segs.seg_delta     <= '0;
        segs.seg_total     <= '0;
        segs.range_hint    <= '0;
        segs.selector_hint <= '0;
        segs.shift_hint    <= '0;
        segs.error         <= 1'b1;
        segs.last          <= 1'b1;
      end else begin
        segs.seg_start     <= TermCode;
        segs.seg_end       <= TermCode;
        segs.seg_delta     <= TermDelta;
        segs.seg_total     <= head.total;
        segs.range_hint    <= range_val;
        segs.selector_hint <= sel;
        segs.shift_hint    <= {head.total[SegW-2:0], 1'b0} - range_val;
        segs.error         <= 1'b0;
        segs.last          <= 1'b1;
      end
    end
  end

endmodule

/* rtl/cmap_format4_segmenter.sv */
// Format-4 character map segment builder, top level.
// Throughput: one item per cycle while the command queue is not full; a finish that closes an
// open segment produces two results in turn, the closed segment and then the terminator. A
// result passes through the command queue write and then the output register, and can wait
// in the queue while the output is stalled.
// Reset (synchronous, active high) clears the segment state, the queue and the output valid.
module cmap_format4_segmenter #(
  parameter int QDEPTH = cmfs_pkg::QDepth
) (
  input logic        clk,
  input logic        rst,
  cmfs_pair_if.sink  pairs,
  cmfs_seg_if.source segments
);
  import cmfs_pkg::*;

  cmd_t       q_cmd;
  cmd_t       q_head;
  fifo_stat_t q_stat;
  logic       q_push;
  logic       q_pop;

  cmfs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pairs  (pairs),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  cmfs_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_cmd),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  cmfs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .segs   (segments)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (segments.valid && segments.error) |-> segments.last)
    else $error("error result not marked last");

  a_term_codes: assert property (@(posedge clk) disable iff (rst)
    (segments.valid && segments.last && !segments.error) |->
      (segments.seg_start == TermCode) && (segments.seg_end == TermCode))
    else $error("last result is not the terminator segment");
`endif

endmodule

/* sim/tb_cmap_format4_segmenter.sv */
// Self-checking testbench for the format-4 character map segment builder.
// Drives pair and finish transfers; checks segments against typed rows or a built-in predictor.
// Depends on cmfs_pkg, the cmfs_pair_if and cmfs_seg_if interfaces, and cmap_format4_segmenter.
`timescale 1ns / 100ps

module tb_cmap_format4_segmenter;
  import cmfs_pkg::*;

  typedef struct packed {
    logic [15:0] seg_start;
    logic [15:0] seg_end;
    logic [15:0] seg_delta;
    logic [15:0] seg_total;
    logic [15:0] range_hint;
    logic [3:0]  selector_hint;
    logic [15:0] shift_hint;
    logic        error;
    logic        last;
  } seg_rec_t;

  typedef struct {
    logic        kind;
    logic [20:0] code;
    logic [15:0] glyph;
    int          n_typed;
    seg_rec_t    typed;
  } stim_row_t;

  localparam int Predicted = -1;
  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 16;
  localparam int RandomPerPhase = 250;
  localparam logic [20:0] CodeMax = 21'h10FFFF;

  localparam seg_rec_t NoSeg = '0;
  localparam seg_rec_t EmptyTerm = '{16'hFFFF, 16'hFFFF, 16'h0001, 16'd1, 16'd2, 4'd0, 16'd0,
                                     1'b0, 1'b1};
  localparam seg_rec_t Rejected = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0, 1'b1, 1'b1};

  logic clk;
  logic rst;

  cmfs_pair_if pairs ();
  cmfs_seg_if segments ();

  cmap_format4_segmenter dut (
    .clk      (clk),
    .rst      (rst),
    .pairs    (pairs),
    .segments (segments)
  );

  logic [15:0] open_start;
  logic [15:0] open_end;
  logic [15:0] open_delta;
  logic        open_valid;
  logic [16:0] segs_closed;
  logic        map_rejected;

  seg_rec_t expected_segs[$];
  int       mismatches = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       quiet_cycles = 0;
  int       hold_left = 0;
  int       hold_token = 0;
  int       hold_seen = 0;

  stim_row_t directed_rows [0:23] = '{
    '{KindFinish, 21'h000000, 16'h0000, 1, EmptyTerm},
    '{KindPair, 21'h000000, 16'h0000, 0, NoSeg},
    '{KindPair, 21'h000001, 16'h0001, 0, NoSeg},
    '{KindPair, 21'h000002, 16'hFFFF, 1,
      '{16'h0000, 16'h0001, 16'h0000, '0, '0, '0, '0, 1'b0, 1'b0}},
    '{KindPair, 21'h00FFFE, 16'h0000, 1,
      '{16'h0002, 16'h0002, 16'hFFFD, '0, '0, '0, '0, 1'b0, 1'b0}},
    '{KindPair, 21'h00FFFF, 16'h0001, 0, NoSeg},
    '{KindFinish, CodeMax, 16'hFFFF, Predicted, NoSeg},
    '{KindPair, 21'h000100, 16'h1234, Predicted, NoSeg},
    '{KindPair, 21'h000080, 16'h11B4, Predicted, NoSeg},
    '{KindPair, 21'h000081, 16'h11B5, Predicted, NoSeg},
    '{KindFinish, 21'h000000, 16'h0000, Predicted, NoSeg},
    '{KindPair, CodeMax, 16'hFFFF, 0, NoSeg},
    '{KindPair, 21'h000005, 16'h0005, 0, NoSeg},
    '{KindFinish, 21'h000000, 16'h0000, 1, Rejected},
    '{KindFinish, 21'h000000, 16'h0000, 1, EmptyTerm},
    '{KindPair, 21'h010000, 16'h0000, 0, NoSeg},
    '{KindFinish, 21'h000000, 16'h0000, 1, Rejected},
    '{KindPair, 21'h00FFFF, 16'hFFFF, 0, NoSeg},
    '{KindPair, 21'h000000, 16'h0000, 1,
      '{16'hFFFF, 16'hFFFF, 16'h0000, '0, '0, '0, '0, 1'b0, 1'b0}},
    '{KindFinish, 21'h000000, 16'h0000, Predicted, NoSeg},
    '{KindPair, 21'h000000, 16'hFFFF, 0, NoSeg},
    '{KindPair, 21'h000001, 16'h0000, 0, NoSeg},
    '{KindPair, 21'h00AAAA, 16'h5555, Predicted, NoSeg},
    '{KindFinish, 21'h0F5555, 16'hAAAA, Predicted, NoSeg}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void forget_map();
    open_start = '0;
    open_end = '0;
    open_delta = '0;
    open_valid = 1'b0;
    segs_closed = '0;
    map_rejected = 1'b0;
  endfunction

  // Returns the number of segments the item emits, in emission order.
  function automatic int segment_step(input logic kind, input logic [20:0] code,
                                      input logic [15:0] glyph, output seg_rec_t first_seg,
                                      output seg_rec_t second_seg);
    int          n;
    int          sel;
    logic [15:0] delta;
    logic [16:0] total;
    logic [16:0] range_w;
    logic [16:0] shift_w;
    seg_rec_t    term;
    n = 0;
    first_seg = '0;
    second_seg = '0;
    if (kind == KindPair) begin
      if (map_rejected) return 0;
      if (code > 21'h00FFFF) begin
        map_rejected = 1'b1;
        return 0;
      end
      delta = glyph - code[15:0];
      if (open_valid && code == {5'b0, open_end} + 21'd1 && delta == open_delta) begin
        open_end = code[15:0];
        return 0;
      end
      if (open_valid) begin
        first_seg = '{open_start, open_end, open_delta, '0, '0, '0, '0, 1'b0, 1'b0};
        n = 1;
        segs_closed = segs_closed + 17'd1;
        if (int'(segs_closed) + 2 > int'(SegLimit)) map_rejected = 1'b1;
      end
      open_start = code[15:0];
      open_end = code[15:0];
      open_delta = delta;
      open_valid = 1'b1;
      return n;
    end
    total = segs_closed + {16'd0, open_valid} + 17'd1;
    if (map_rejected || total > SegLimit) begin
      first_seg = Rejected;
      forget_map();
      return 1;
    end
    if (open_valid) begin
      first_seg = '{open_start, open_end, open_delta, '0, '0, '0, '0, 1'b0, 1'b0};
      n = 1;
    end
    sel = 0;
    while (sel < 15 && (total >> (sel + 1)) != 0) sel++;
    range_w = 17'd2 << sel;
    shift_w = (total << 1) - range_w;
    term = '{TermCode, TermCode, TermDelta, total[15:0], range_w[15:0], sel[3:0],
             shift_w[15:0], 1'b0, 1'b1};
    if (n == 0) first_seg = term;
    else second_seg = term;
    forget_map();
    return n + 1;
  endfunction

  task automatic apply_item(input logic kind, input logic [20:0] code, input logic [15:0] glyph,
                            input int n_typed, input seg_rec_t typed);
    seg_rec_t a;
    seg_rec_t b;
    int       n;
    while ($urandom_range(1, 100) <= idle_pct) begin
      pairs.valid <= 1'b0;
      @(posedge clk);
    end
    pairs.valid <= 1'b1;
    pairs.kind <= kind;
    pairs.code <= code;
    pairs.glyph <= glyph;
    @(posedge clk);
    while (!pairs.ready) @(posedge clk);
    n = segment_step(kind, code, glyph, a, b);
    if (n_typed == Predicted) begin
      if (n > 0) expected_segs = {expected_segs, a};
      if (n > 1) expected_segs = {expected_segs, b};
    end else if (n_typed > 0) begin
      expected_segs = {expected_segs, typed};
    end
  endtask

  task automatic random_maps(input int target);
    int          done;
    int          len;
    int          r;
    logic [20:0] code;
    logic [15:0] glyph;
    logic [15:0] delta;
    done = 0;
    while (done < target) begin
      len = $urandom_range(1, 24);
      if ($urandom_range(0, 7) == 0) code = 21'($urandom_range(16'hFF00, 16'hFFFF));
      else code = 21'($urandom_range(0, 16'hF000));
      delta = 16'($urandom);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (i == 0) begin
        end else if (r < 3) begin
          code = 21'($urandom_range(0, 32'h10FFFF));
        end else if (r < 6) begin
          code = 21'($urandom_range(0, 16'hFFFF));
        end else if (r < 66) begin
          code = code + 21'd1;
        end else begin
          code = code + 21'($urandom_range(2, 600));
        end
        if (code > CodeMax) code = CodeMax;
        if (r >= 6 && r < 66 && $urandom_range(0, 3) != 0) glyph = code[15:0] + delta;
        else glyph = 16'($urandom);
        delta = glyph - code[15:0];
        done++;
        apply_item(KindPair, code, glyph, Predicted, NoSeg);
        if ($urandom_range(0, 39) == 0) begin
          done++;
          apply_item(KindFinish, 21'($urandom_range(0, 32'h10FFFF)), 16'($urandom),
                     Predicted, NoSeg);
        end
      end
      done++;
      apply_item(KindFinish, 21'($urandom_range(0, 32'h10FFFF)), 16'($urandom),
                 Predicted, NoSeg);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    seg_rec_t want;
    if (!rst && segments.valid && segments.ready) begin
      if (expected_segs.size() == 0) begin
        $error("segment transfer with no expected segment: start %0h end %0h",
               segments.seg_start, segments.seg_end);
        mismatches++;
      end else begin
        want = expected_segs.pop_front();
        check_field("seg_start", want.seg_start, segments.seg_start);
        check_field("seg_end", want.seg_end, segments.seg_end);
        check_field("seg_delta", want.seg_delta, segments.seg_delta);
        check_field("seg_total", want.seg_total, segments.seg_total);
        check_field("range_hint", want.range_hint, segments.range_hint);
        check_field("selector_hint", 16'(want.selector_hint), 16'(segments.selector_hint));
        check_field("shift_hint", want.shift_hint, segments.shift_hint);
        check_field("error", 16'(want.error), 16'(segments.error));
        check_field("last", 16'(want.last), 16'(segments.last));
      end
    end
    if (rst) begin
      segments.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HoldCycles;
      segments.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      segments.ready <= 1'b0;
    end else begin
      segments.ready <= ($urandom_range(1, 100) > stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pairs.valid && pairs.ready) || (segments.valid && segments.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    pairs.valid <= 1'b0;
    pairs.kind <= KindPair;
    pairs.code <= '0;
    pairs.glyph <= '0;
    forget_map();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      apply_item(directed_rows[i].kind, directed_rows[i].code, directed_rows[i].glyph,
                 directed_rows[i].n_typed, directed_rows[i].typed);
    end

    hold_token <= hold_token + 1;
    random_maps(RandomPerPhase);
    idle_pct = 78;
    random_maps(RandomPerPhase);
    idle_pct = 0;
    stall_pct = 78;
    random_maps(RandomPerPhase);
    idle_pct = 29;
    stall_pct = 29;
    random_maps(RandomPerPhase);
    pairs.valid <= 1'b0;

    while (expected_segs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cmfs_pkg.sv
rtl/cmfs_if.sv
rtl/cmfs_front.sv
rtl/cmfs_fifo.sv
rtl/cmfs_back.sv
rtl/cmap_format4_segmenter.sv
sim/tb_cmap_format4_segmenter.sv
